@@ rtl/sipd_pkg.sv @@
// sipd_pkg: shared widths, character codes and sequencer states for the
// signed integer to padded decimal converter. No dependencies.
`timescale 1ns / 1ps

package sipd_pkg;

   localparam int VALUE_W      = 32;            // input integer width
   localparam int CHAR_W       = 8;             // ASCII character width
   localparam int WIDTH_W      = 6;             // min_width register width
   localparam int DIGIT_W      = 4;             // one BCD digit
   localparam int NUM_DIGITS   = 10;            // 2^32 has ten decimal digits
   localparam int BCD_W        = NUM_DIGITS * DIGIT_W;
   localparam int DIGIT_IDX_W  = $clog2(NUM_DIGITS);
   localparam int STEP_CNT_W   = $clog2(VALUE_W);
   localparam int MAX_FIELD_DEFAULT = 32;

   localparam logic [WIDTH_W-1:0]     WIDTH_RESET = 6'd10;
   localparam logic [DIGIT_W-1:0]     DIGIT_FIVE  = 4'd5;
   localparam logic [DIGIT_W-1:0]     DIGIT_THREE = 4'd3;
   localparam logic [DIGIT_W-1:0]     DIGIT_TEN   = 4'd10;
   localparam logic [CHAR_W-1:0]      CHAR_BLANK  = 8'h20;
   localparam logic [CHAR_W-1:0]      CHAR_MINUS  = 8'h2D;
   localparam logic [CHAR_W-1:0]      CHAR_ZERO   = 8'h30;
   localparam logic [STEP_CNT_W-1:0]  LAST_STEP   = STEP_CNT_W'(VALUE_W - 1);

   // control from the sequencer to the shift-add-3 unit
   typedef struct packed {
      logic load;   // take a new magnitude, clear the BCD digits
      logic step;   // one correct-and-shift step
   } dab_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_PREP = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

endpackage

@@ rtl/sipd_if.sv @@
// sipd_if: valid/ready channel interfaces for the request (integer) and
// response (character) beats. Depends on sipd_pkg.
`timescale 1ns / 1ps

interface sipd_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [sipd_pkg::VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sipd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sipd_pkg::CHAR_W-1:0]  char_code;
   logic                         last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

@@ rtl/sipd_dabble.sv @@
// sipd_dabble: shift-add-3 binary to BCD unit, one bit per step.
// Depends on sipd_pkg.
`timescale 1ns / 1ps

module sipd_dabble (
   input  logic                           clock,
   input  sipd_pkg::dab_ctrl_type         ctrl,
   input  logic [sipd_pkg::VALUE_W-1:0]   load_value,
   output logic [sipd_pkg::BCD_W-1:0]     bcd
);

   logic [sipd_pkg::VALUE_W-1:0] bin_ff, bin_in;
   logic [sipd_pkg::BCD_W-1:0]   bcd_ff, bcd_in;
   logic [sipd_pkg::BCD_W-1:0]   bcd_adj;

   // digits of 5 or more get +3 before the shift
   always_comb begin
      for (int i = 0; i < sipd_pkg::NUM_DIGITS; i++) begin
         if (bcd_ff[i*sipd_pkg::DIGIT_W +: sipd_pkg::DIGIT_W] >= sipd_pkg::DIGIT_FIVE) begin
            bcd_adj[i*sipd_pkg::DIGIT_W +: sipd_pkg::DIGIT_W] =
               bcd_ff[i*sipd_pkg::DIGIT_W +: sipd_pkg::DIGIT_W] + sipd_pkg::DIGIT_THREE;
         end else begin
            bcd_adj[i*sipd_pkg::DIGIT_W +: sipd_pkg::DIGIT_W] =
               bcd_ff[i*sipd_pkg::DIGIT_W +: sipd_pkg::DIGIT_W];
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (ctrl.load) begin
         bin_in = load_value;
         bcd_in = '0;
      end else if (ctrl.step) begin
         {bcd_in, bin_in} = {bcd_adj[sipd_pkg::BCD_W-2:0], bin_ff, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign bcd = bcd_ff;

endmodule

@@ rtl/signed_int_to_padded_decimal_core.sv @@
// signed_int_to_padded_decimal_core: top level, sequencer and character
// emitter around the shared shift-add-3 unit. Depends on sipd_pkg,
// sipd_if and sipd_dabble.
`timescale 1ns / 1ps

// Converts one signed 32-bit integer per request beat into its decimal
// ASCII text, one character per response beat, most significant first:
// leading blanks up to the minimum field width, a minus sign for negative
// values, then the digits; last_char marks the final digit. The field width
// comes from min_width_ff (reset 10) and saturates at MAX_FIELD; text that
// is already wider is never cut. The magnitude goes through one shift-add-3
// BCD unit, one bit per cycle. Each item passes through an idle state in
// which the request beat is taken, a conversion state with one step per
// magnitude bit, a setup state and an emit state that sends max(field width,
// text length) characters, each once the output register is empty or being
// taken. The request side is ready only while idle; it returns to idle as
// soon as the last character enters the output register, so the next
// conversion overlaps that drain.
module signed_int_to_padded_decimal_core #(
   parameter int MAX_FIELD = sipd_pkg::MAX_FIELD_DEFAULT   // 11 .. 64
) (
   input  logic                            clock,
   input  logic                            reset,
   sipd_req_if.sink                        req_bus,
   sipd_rsp_if.source                      rsp_bus,
   input  logic                            csr_we,
   input  logic [sipd_pkg::WIDTH_W-1:0]    csr_wdata
);

   localparam int CNT_W = $clog2(MAX_FIELD + 1);

   sipd_pkg::state_type               state_ff, state_in;
   logic [sipd_pkg::WIDTH_W-1:0]      min_width_ff, min_width_in;
   logic [sipd_pkg::STEP_CNT_W-1:0]   step_ff, step_in;
   logic                              neg_ff, neg_in;
   logic [CNT_W-1:0]                  total_ff, total_in;   // characters to emit
   logic [CNT_W-1:0]                  pad_ff, pad_in;       // leading blanks
   logic [CNT_W-1:0]                  pos_ff, pos_in;       // next character
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [sipd_pkg::CHAR_W-1:0]       rsp_char_ff, rsp_char_in;
   logic                              rsp_last_ff, rsp_last_in;

   sipd_pkg::dab_ctrl_type            dab_ctrl;
   logic [sipd_pkg::VALUE_W-1:0]      magnitude;
   logic [sipd_pkg::BCD_W-1:0]        bcd;

   logic                              req_acc;
   logic                              emit_load;
   logic                              emit_last;
   logic                              in_digits;
   logic [sipd_pkg::DIGIT_IDX_W:0]    num_digits;   // 1 .. 10
   logic [CNT_W-1:0]                  text_len;     // digits plus sign
   logic [CNT_W-1:0]                  width_sat;
   logic [CNT_W-1:0]                  digit_pos;    // 0 is least significant
   logic [sipd_pkg::DIGIT_IDX_W-1:0]  digit_idx;
   logic [sipd_pkg::DIGIT_W-1:0]      digit;
   logic [sipd_pkg::CHAR_W-1:0]       next_char;

   assign req_bus.ready = (state_ff == sipd_pkg::ST_IDLE);
   assign req_acc       = req_bus.valid && req_bus.ready;

   // unsigned magnitude; the most negative value maps to 2^31 cleanly
   assign magnitude = req_bus.value[sipd_pkg::VALUE_W-1] ?
                      (sipd_pkg::VALUE_W'(0) - sipd_pkg::VALUE_W'(req_bus.value)) :
                      sipd_pkg::VALUE_W'(req_bus.value);

   assign dab_ctrl.load = req_acc;
   assign dab_ctrl.step = (state_ff == sipd_pkg::ST_CONV);

   sipd_dabble u_dabble (
      .clock      (clock),
      .ctrl       (dab_ctrl),
      .load_value (magnitude),
      .bcd        (bcd)
   );

   // significant digit count: highest nonzero digit, zero still shows one
   always_comb begin
      num_digits = (sipd_pkg::DIGIT_IDX_W + 1)'(1);
      for (int i = 1; i < sipd_pkg::NUM_DIGITS; i++) begin
         if (bcd[i*sipd_pkg::DIGIT_W +: sipd_pkg::DIGIT_W] != '0) begin
            num_digits = (sipd_pkg::DIGIT_IDX_W + 1)'(i + 1);
         end
      end
   end

   assign text_len  = CNT_W'(num_digits) + CNT_W'(neg_ff);
   assign width_sat = (int'(min_width_ff) > MAX_FIELD) ? CNT_W'(MAX_FIELD) :
                                                         CNT_W'(min_width_ff);

   // character at the current position
   assign digit_pos = total_ff - pos_ff - CNT_W'(1);
   assign digit_idx = digit_pos[sipd_pkg::DIGIT_IDX_W-1:0];
   assign in_digits = (pos_ff > pad_ff) || ((pos_ff == pad_ff) && !neg_ff);

   always_comb begin
      digit = '0;
      for (int i = 0; i < sipd_pkg::NUM_DIGITS; i++) begin
         if (digit_idx == sipd_pkg::DIGIT_IDX_W'(i)) begin
            digit = bcd[i*sipd_pkg::DIGIT_W +: sipd_pkg::DIGIT_W];
         end
      end
   end

   always_comb begin
      if (pos_ff < pad_ff) begin
         next_char = sipd_pkg::CHAR_BLANK;
      end else if (!in_digits) begin
         next_char = sipd_pkg::CHAR_MINUS;
      end else begin
         next_char = sipd_pkg::CHAR_ZERO + sipd_pkg::CHAR_W'(digit);
      end
   end

   assign emit_load = (state_ff == sipd_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_bus.ready);
   assign emit_last = (pos_ff == total_ff - CNT_W'(1));

   always_comb begin
      state_in     = state_ff;
      min_width_in = csr_we ? csr_wdata : min_width_ff;
      step_in      = step_ff;
      neg_in       = neg_ff;
      total_in     = total_ff;
      pad_in       = pad_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         sipd_pkg::ST_IDLE: begin
            if (req_acc) begin
               neg_in   = req_bus.value[sipd_pkg::VALUE_W-1];
               step_in  = '0;
               state_in = sipd_pkg::ST_CONV;
            end
         end
         sipd_pkg::ST_CONV: begin
            step_in = step_ff + sipd_pkg::STEP_CNT_W'(1);
            if (step_ff == sipd_pkg::LAST_STEP) begin
               state_in = sipd_pkg::ST_PREP;
            end
         end
         sipd_pkg::ST_PREP: begin
            // text as long as the field or longer: no blanks
            if (width_sat > text_len) begin
               total_in = width_sat;
               pad_in   = width_sat - text_len;
            end else begin
               total_in = text_len;
               pad_in   = '0;
            end
            pos_in   = '0;
            state_in = sipd_pkg::ST_EMIT;
         end
         sipd_pkg::ST_EMIT: begin
            if (emit_load) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = next_char;
               rsp_last_in  = emit_last;
               pos_in       = pos_ff + CNT_W'(1);
               if (emit_last) begin
                  state_in = sipd_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sipd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sipd_pkg::ST_IDLE;
         min_width_ff <= sipd_pkg::WIDTH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_width_ff <= min_width_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      neg_ff      <= neg_in;
      total_ff    <= total_in;
      pad_ff      <= pad_in;
      pos_ff      <= pos_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.char_code = rsp_char_ff;
   assign rsp_bus.last_char = rsp_last_ff;

   // conversion always takes exactly one step per magnitude bit
   a_conv_length: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> ##33 (state_ff == sipd_pkg::ST_PREP))
      else $error("conversion length wrong");

   // the BCD unit must only ever hand out decimal digits
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (emit_load && in_digits) |-> (digit < sipd_pkg::DIGIT_TEN))
      else $error("non-decimal BCD digit");

   // field length stays within the cap and is never empty
   a_total_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sipd_pkg::ST_EMIT) |->
         ((total_ff != '0) && (int'(total_ff) <= MAX_FIELD) && (pad_ff < total_ff)))
      else $error("field length out of range");

endmodule
